// File: hw/rtl/stxrx_pkg.sv
// ----------------------------------------------------------------------------
// stxrx_pkg
// Shared types and constants for the framed byte-stream receiver.
// ----------------------------------------------------------------------------
package stxrx_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int BYTE_W       = 8;
   localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int LEN_W        = 7;
   localparam int TDATA_W      = 24;

   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

   // Configuration register indexes
   localparam logic [1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [1:0] CSR_END_BYTE     = 2'd1;
   localparam logic [1:0] CSR_LENGTH_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      PH_WAIT_START,
      PH_LENGTH,
      PH_DATA,
      PH_CHECK,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [LEN_W-1:0]  length_limit;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] length;
   } frame_done_type;

endpackage

// File: hw/rtl/stx_length_checksum_frame_receiver_top.sv
// Payload, length and checksum bytes are taken one per cycle.
// After the end byte transfer the run flag, buffer read and output stage register
// in turn; then one result per ready cycle from the single buffer read port.
// Input is stalled from the end byte until the last result has been taken.
// Synchronous reset returns to waiting for a start byte; buffer needs no clearing.
// ----------------------------------------------------------------------------
// stx_length_checksum_frame_receiver_top
// Framed byte-stream receiver with payload buffer and burst readout.
// ----------------------------------------------------------------------------
module stx_length_checksum_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [13:8] byte_position,
                                    // [20:14] frame_length, [23:21] zero
   output logic        rsp_tlast    // last_of_frame
);
   import stxrx_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   ram_wr_type      ram_wr;
   frame_done_type  frame_done;
   logic            in_fire;
   logic            busy;
   logic            rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] out_byte;
   logic [ADDR_W-1:0] out_pos;
   logic [LEN_W-1:0]  out_len;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_BYTE:   cfg_in.start_byte   = csr_wdata;
            CSR_END_BYTE:     cfg_in.end_byte     = csr_wdata;
            CSR_LENGTH_LIMIT: cfg_in.length_limit = csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= 8'h02;
         cfg_ff.end_byte     <= 8'h03;
         cfg_ff.length_limit <= LEN_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !busy;
   assign in_fire    = req_tvalid && req_tready;

   stxrx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_fire    (in_fire),
      .in_byte    (req_tdata),
      .ram_wr     (ram_wr),
      .frame_done (frame_done)
   );

   stxrx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stxrx_readout u_readout (
      .clock      (clock),
      .reset      (reset),
      .frame_done (frame_done),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_pos    (out_pos),
      .out_len    (out_len),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_len, 6'(out_pos), out_byte};

endmodule

// File: hw/rtl/stxrx_ram.sv
// ----------------------------------------------------------------------------
// stxrx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stxrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/stxrx_parser.sv
// ----------------------------------------------------------------------------
// stxrx_parser
// Frame state machine: start, length, payload, checksum and end byte.
// ----------------------------------------------------------------------------
module stxrx_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  stxrx_pkg::cfg_type        cfg,
   input  logic                      in_fire,
   input  logic [7:0]                in_byte,
   output stxrx_pkg::ram_wr_type     ram_wr,
   output stxrx_pkg::frame_done_type frame_done
);
   import stxrx_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   wpos_ff, wpos_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]   eff_limit;
   logic               len_ok;
   logic [LEN_W-1:0]   remain_dec;

   assign eff_limit  = (cfg.length_limit > DEPTH_LEN) ? DEPTH_LEN : cfg.length_limit;
   assign len_ok     = (in_byte != '0) && ({1'b0, in_byte} <= {2'b00, eff_limit});
   assign remain_dec = remain_ff - LEN_W'(1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (in_fire) begin
         unique case (phase_ff)
            PH_WAIT_START: begin
               if (in_byte == cfg.start_byte) phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               phase_in = len_ok ? PH_DATA : PH_WAIT_START;
            end
            PH_DATA: begin
               if (remain_dec == '0) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in = (in_byte == sum_ff) ? PH_END : PH_WAIT_START;
            end
            PH_END: begin
               phase_in = PH_WAIT_START;
            end
            default: begin
               phase_in = PH_WAIT_START;
            end
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      wpos_in           = wpos_ff;
      remain_in         = remain_ff;
      sum_in            = sum_ff;
      ram_wr.en         = 1'b0;
      ram_wr.addr       = wpos_ff[ADDR_W-1:0];
      ram_wr.data       = in_byte;
      frame_done.start  = 1'b0;
      frame_done.length = wpos_ff;
      if (in_fire) begin
         unique case (phase_ff)
            PH_WAIT_START: begin
               if (in_byte == cfg.start_byte) begin
                  wpos_in   = '0;
                  remain_in = '0;
                  sum_in    = '0;
               end
            end
            PH_LENGTH: begin
               if (len_ok) remain_in = in_byte[LEN_W-1:0];
            end
            PH_DATA: begin
               if (wpos_ff < DEPTH_LEN) begin
                  ram_wr.en = 1'b1;
                  wpos_in   = wpos_ff + LEN_W'(1);
               end
               sum_in    = sum_ff + in_byte;
               remain_in = remain_dec;
            end
            PH_CHECK: begin
            end
            PH_END: begin
               frame_done.start = (in_byte == cfg.end_byte) && (wpos_ff != '0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_START;
         wpos_ff   <= '0;
         remain_ff <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         wpos_ff   <= wpos_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

// File: hw/rtl/stxrx_readout.sv
// ----------------------------------------------------------------------------
// stxrx_readout
// Burst reader: walks the payload buffer and feeds a two-entry output stage.
// ----------------------------------------------------------------------------
module stxrx_readout (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stxrx_pkg::frame_done_type            frame_done,
   output logic                                 rd_en,
   output logic [stxrx_pkg::ADDR_W-1:0]         rd_addr,
   input  logic [stxrx_pkg::BYTE_W-1:0]         rd_data,
   output logic                                 busy,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [stxrx_pkg::BYTE_W-1:0]         out_byte,
   output logic [stxrx_pkg::ADDR_W-1:0]         out_pos,
   output logic [stxrx_pkg::LEN_W-1:0]          out_len,
   output logic                                 out_last
);
   import stxrx_pkg::*;

   logic               run_ff, run_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               fly_ff, fly_in;
   logic [ADDR_W-1:0]  fly_pos_ff;
   logic               fly_last_ff;

   logic               head_vld_ff, head_vld_in;
   logic [BYTE_W-1:0]  head_byte_ff, head_byte_in;
   logic [ADDR_W-1:0]  head_pos_ff, head_pos_in;
   logic               head_last_ff, head_last_in;
   logic               skid_vld_ff, skid_vld_in;
   logic [BYTE_W-1:0]  skid_byte_ff, skid_byte_in;
   logic [ADDR_W-1:0]  skid_pos_ff, skid_pos_in;
   logic               skid_last_ff, skid_last_in;

   logic               pop;
   logic [1:0]         load;
   logic               issue;
   logic [LEN_W-1:0]   idx_next;

   assign pop      = head_vld_ff && out_ready;
   assign load     = 2'({1'b0, head_vld_ff}) + 2'({1'b0, skid_vld_ff}) + 2'({1'b0, fly_ff})
                     - 2'({1'b0, pop});
   // only issue a read when the output stage has room for it on arrival
   assign issue    = run_ff && (load < 2'd2);
   assign idx_next = idx_ff + LEN_W'(1);

   assign rd_en   = issue;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      fly_in = issue;
      if (frame_done.start) begin
         run_in = 1'b1;
         idx_in = '0;
         len_in = frame_done.length;
      end else if (issue) begin
         idx_in = idx_next;
         run_in = (idx_next != len_ff);
      end
   end

   // two-entry output stage
   always_comb begin
      head_vld_in  = head_vld_ff;
      head_byte_in = head_byte_ff;
      head_pos_in  = head_pos_ff;
      head_last_in = head_last_ff;
      skid_vld_in  = skid_vld_ff;
      skid_byte_in = skid_byte_ff;
      skid_pos_in  = skid_pos_ff;
      skid_last_in = skid_last_ff;
      if (pop || !head_vld_ff) begin
         if (skid_vld_ff) begin
            head_vld_in  = 1'b1;
            head_byte_in = skid_byte_ff;
            head_pos_in  = skid_pos_ff;
            head_last_in = skid_last_ff;
            skid_vld_in  = fly_ff;
            skid_byte_in = rd_data;
            skid_pos_in  = fly_pos_ff;
            skid_last_in = fly_last_ff;
         end else begin
            head_vld_in  = fly_ff;
            head_byte_in = rd_data;
            head_pos_in  = fly_pos_ff;
            head_last_in = fly_last_ff;
         end
      end else if (fly_ff) begin
         skid_vld_in  = 1'b1;
         skid_byte_in = rd_data;
         skid_pos_in  = fly_pos_ff;
         skid_last_in = fly_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         idx_ff      <= '0;
         len_ff      <= '0;
         fly_ff      <= 1'b0;
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         fly_ff      <= fly_in;
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fly_pos_ff   <= idx_ff[ADDR_W-1:0];
      fly_last_ff  <= (idx_next == len_ff);
      head_byte_ff <= head_byte_in;
      head_pos_ff  <= head_pos_in;
      head_last_ff <= head_last_in;
      skid_byte_ff <= skid_byte_in;
      skid_pos_ff  <= skid_pos_in;
      skid_last_ff <= skid_last_in;
   end

   assign busy      = run_ff || fly_ff || head_vld_ff || skid_vld_ff;
   assign out_valid = head_vld_ff;
   assign out_byte  = head_byte_ff;
   assign out_pos   = head_pos_ff;
   assign out_len   = len_ff;
   assign out_last  = head_last_ff;

endmodule
